// ===== rtl/olad_pkg.sv =====
// olad_pkg: shared types and constants for the ordered list block.
// Request and status codes, cell commands and the control state type.
// No dependencies.
package olad_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int VAL_W            = 32;
  localparam int REQ_W            = 2;
  localparam int STATUS_W         = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_APPENDED = 3'd0,
    STAT_DELETED  = 3'd1,
    STAT_NOTFOUND = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_LISTED   = 3'd4,
    STAT_FULL     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_APPEND = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  typedef struct packed {
    cell_op_e                 op;
    logic signed [VAL_W-1:0]  item;
  } cell_cmd_t;

endpackage

// ===== rtl/olad_cell.sv =====
// olad_cell: one list slot holding a value and its valid flag.
// Uses olad_pkg for the command struct; chained head to tail by the top level.
module olad_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  olad_pkg::cell_cmd_t               cmd_i,
  input  logic signed [olad_pkg::VAL_W-1:0] head_value_i,
  input  logic                              prev_valid_i,
  input  logic signed [olad_pkg::VAL_W-1:0] next_value_i,
  input  logic                              next_valid_i,
  input  logic                              seen_i,
  output logic signed [olad_pkg::VAL_W-1:0] value_o,
  output logic                              valid_o,
  output logic                              seen_o
);

  logic signed [olad_pkg::VAL_W-1:0] value_q, value_d;
  logic                              valid_q, valid_d;
  logic                              match;

  assign match  = valid_q && (value_q == cmd_i.item);
  // set from the first matching slot onwards
  assign seen_o = seen_i | match;

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    case (cmd_i.op)
      olad_pkg::CELL_APPEND: begin
        // first free slot takes the new value
        if (!valid_q && prev_valid_i) begin
          value_d = cmd_i.item;
          valid_d = 1'b1;
        end
      end
      olad_pkg::CELL_DELETE: begin
        if (seen_o) begin
          value_d = next_value_i;
          valid_d = next_valid_i;
        end
      end
      olad_pkg::CELL_ROTATE: begin
        // tail slot picks up the old head, the rest move up
        if (valid_q) begin
          value_d = next_valid_i ? next_value_i : head_value_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

// ===== rtl/ordered_list_append_delete.sv =====
// ordered_list_append_delete: top level, control and chain of list cells.
// Depends on olad_pkg and olad_cell.
//
// Holds up to CAPACITY signed 32-bit values in append order, one per cell of a
// head-to-tail chain. Append and delete take one beat in and give one beat out;
// each is done on acceptance, all cells comparing in parallel and the cells
// behind a deleted match moving up one place as it is accepted. A
// read out gives one beat per held entry, last flagged, or a single empty beat;
// a non-empty read out loads one entry each time the output register is free, while
// the chain rotates its valid entries past the head, and input is stalled until
// the final beat is in the output register. Results pass through a one-deep
// output register; input is stalled while a result waits there under output
// stall, so a new request is taken only in a cycle where that register is empty
// or its beat leaves. Request type 3 is consumed with no result. No clearing
// pass after reset.
module ordered_list_append_delete #(
  parameter int CAPACITY = olad_pkg::DEFAULT_CAPACITY
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [olad_pkg::REQ_W-1:0]           req_type_i,
  input  logic signed [olad_pkg::VAL_W-1:0]    item_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [olad_pkg::VAL_W-1:0]    result_value_o,
  output logic [olad_pkg::STATUS_W-1:0]        status_o,
  output logic                                 last_o
);

  localparam int CntW = $clog2(CAPACITY + 1);

  olad_pkg::state_e    state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     rem_q, rem_d;
  olad_pkg::cell_cmd_t cmd;

  logic                              out_valid_q;
  logic signed [olad_pkg::VAL_W-1:0] res_value_q, res_value_d;
  olad_pkg::status_e                 res_status_q, res_status_d;
  logic                              res_last_q, res_last_d;
  logic                              load_out;

  logic signed [olad_pkg::VAL_W-1:0] cell_value [CAPACITY];
  logic                              cell_valid [CAPACITY];
  logic                              seen       [CAPACITY+1];

  logic in_acc, out_free, full, found;

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [olad_pkg::VAL_W-1:0] nxt_value;
    logic                              nxt_valid;
    logic                              prv_valid;
    if (i == CAPACITY - 1) begin : g_tail
      assign nxt_value = '0;
      assign nxt_valid = 1'b0;
    end else begin : g_mid
      assign nxt_value = cell_value[i+1];
      assign nxt_valid = cell_valid[i+1];
    end
    if (i == 0) begin : g_head
      assign prv_valid = 1'b1;
    end else begin : g_body
      assign prv_valid = cell_valid[i-1];
    end
    olad_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .head_value_i (cell_value[0]),
      .prev_valid_i (prv_valid),
      .next_value_i (nxt_value),
      .next_valid_i (nxt_valid),
      .seen_i       (seen[i]),
      .value_o      (cell_value[i]),
      .valid_o      (cell_valid[i]),
      .seen_o       (seen[i+1])
    );
  end

  assign found      = seen[CAPACITY];
  assign full       = (cnt_q == CntW'(CAPACITY));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q == olad_pkg::S_READ) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rem_d        = rem_q;
    cmd.op       = olad_pkg::CELL_HOLD;
    cmd.item     = item_value_i;
    load_out     = 1'b0;
    res_value_d  = item_value_i;
    res_status_d = olad_pkg::STAT_EMPTY;
    res_last_d   = 1'b1;
    case (state_q)
      olad_pkg::S_IDLE: begin
        if (in_acc) begin
          case (olad_pkg::req_e'(req_type_i))
            olad_pkg::REQ_APPEND: begin
              cmd.op   = olad_pkg::CELL_APPEND;
              load_out = 1'b1;
              if (full) begin
                res_status_d = olad_pkg::STAT_FULL;
              end else begin
                res_status_d = olad_pkg::STAT_APPENDED;
                cnt_d        = cnt_q + CntW'(1);
              end
            end
            olad_pkg::REQ_DELETE: begin
              cmd.op   = olad_pkg::CELL_DELETE;
              load_out = 1'b1;
              if (cnt_q == '0) begin
                res_status_d = olad_pkg::STAT_EMPTY;
              end else if (found) begin
                res_status_d = olad_pkg::STAT_DELETED;
                cnt_d        = cnt_q - CntW'(1);
              end else begin
                res_status_d = olad_pkg::STAT_NOTFOUND;
              end
            end
            olad_pkg::REQ_READ: begin
              if (cnt_q == '0) begin
                load_out     = 1'b1;
                res_value_d  = '0;
                res_status_d = olad_pkg::STAT_EMPTY;
              end else begin
                state_d = olad_pkg::S_READ;
                rem_d   = cnt_q;
              end
            end
            default: begin
            end
          endcase
        end
      end
      olad_pkg::S_READ: begin
        if (out_free) begin
          cmd.op       = olad_pkg::CELL_ROTATE;
          load_out     = 1'b1;
          res_value_d  = cell_value[0];
          res_status_d = olad_pkg::STAT_LISTED;
          res_last_d   = (rem_q == CntW'(1));
          rem_d        = rem_q - CntW'(1);
          if (rem_q == CntW'(1)) begin
            state_d = olad_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = olad_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olad_pkg::S_IDLE;
      cnt_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_value_q  <= res_value_d;
      res_status_q <= res_status_d;
      res_last_q   <= res_last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_value_q;
  assign status_o       = res_status_q;
  assign last_o         = res_last_q;

endmodule
